### design/ricc_pkg.sv
// shared types, constants and instruction decoders for the coverage counter
`default_nettype none
package ricc_pkg;

  localparam int unsigned NumClasses = 171;
  localparam int unsigned IdxW = 8;

  typedef enum logic [1:0] {
    KIND_NOTE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] insn;
    logic        is_compressed;
    logic [7:0]  read_index;
  } item_in_t;

  typedef struct packed {
    logic [7:0]  class_index;
    logic        recognized;
    logic [31:0] count_value;
    logic [7:0]  distinct_seen;
  } item_out_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] cls;
  } dec_t;

  // class numbers
  localparam logic [7:0] C_LUI = 8'd0, C_AUIPC = 8'd1, C_JAL = 8'd2, C_JALR = 8'd3;
  localparam logic [7:0] C_BEQ = 8'd4, C_BNE = 8'd5, C_BLT = 8'd6, C_BGE = 8'd7;
  localparam logic [7:0] C_BLTU = 8'd8, C_BGEU = 8'd9;
  localparam logic [7:0] C_LB = 8'd10, C_LH = 8'd11, C_LW = 8'd12, C_LBU = 8'd13;
  localparam logic [7:0] C_LHU = 8'd14, C_SB = 8'd15, C_SH = 8'd16, C_SW = 8'd17;
  localparam logic [7:0] C_ADDI = 8'd18, C_SLTI = 8'd19, C_SLTIU = 8'd20, C_XORI = 8'd21;
  localparam logic [7:0] C_ORI = 8'd22, C_ANDI = 8'd23, C_SLLI = 8'd24, C_SRLI = 8'd25;
  localparam logic [7:0] C_SRAI = 8'd26, C_ADD = 8'd27, C_SUB = 8'd28, C_SLL = 8'd29;
  localparam logic [7:0] C_SLT = 8'd30, C_SLTU = 8'd31, C_XOR = 8'd32, C_SRL = 8'd33;
  localparam logic [7:0] C_SRA = 8'd34, C_OR = 8'd35, C_AND = 8'd36, C_FENCE = 8'd37;
  localparam logic [7:0] C_FENCEI = 8'd38, C_ECALL = 8'd39, C_EBRK = 8'd40;
  localparam logic [7:0] C_MRET = 8'd41, C_WFI = 8'd42, C_CSRRW = 8'd43, C_CSRRS = 8'd44;
  localparam logic [7:0] C_CSRRC = 8'd45, C_CSRRWI = 8'd46, C_CSRRSI = 8'd47;
  localparam logic [7:0] C_CSRRCI = 8'd48, C_MUL = 8'd49;
  localparam logic [7:0] C_LRW = 8'd57, C_SCW = 8'd58, C_AMOSWAP = 8'd59, C_AMOADD = 8'd60;
  localparam logic [7:0] C_AMOXOR = 8'd61, C_AMOAND = 8'd62, C_AMOOR = 8'd63;
  localparam logic [7:0] C_AMOMIN = 8'd64, C_AMOMAX = 8'd65, C_AMOMINU = 8'd66;
  localparam logic [7:0] C_AMOMAXU = 8'd67, C_FLW = 8'd68, C_FSW = 8'd69;
  localparam logic [7:0] C_FADD = 8'd70, C_FSUB = 8'd71, C_FMUL = 8'd72, C_FDIV = 8'd73;
  localparam logic [7:0] C_FSQRT = 8'd74, C_FSGNJ = 8'd75, C_FSGNJN = 8'd76;
  localparam logic [7:0] C_FSGNJX = 8'd77, C_FMIN = 8'd78, C_FMAX = 8'd79, C_FEQ = 8'd80;
  localparam logic [7:0] C_FLT = 8'd81, C_FLE = 8'd82, C_FCLASS = 8'd83;
  localparam logic [7:0] C_FCVTWS = 8'd84, C_FCVTWUS = 8'd85, C_FCVTSW = 8'd86;
  localparam logic [7:0] C_FCVTSWU = 8'd87, C_FMVXW = 8'd88, C_FMVWX = 8'd89;
  localparam logic [7:0] C_FMADD = 8'd90, C_FMSUB = 8'd91, C_FNMSUB = 8'd92;
  localparam logic [7:0] C_FNMADD = 8'd93, C_SH1ADD = 8'd94, C_SH2ADD = 8'd95;
  localparam logic [7:0] C_SH3ADD = 8'd96, C_ANDN = 8'd97, C_ORN = 8'd98, C_XNOR = 8'd99;
  localparam logic [7:0] C_MIN = 8'd100, C_MINU = 8'd101, C_MAX = 8'd102, C_MAXU = 8'd103;
  localparam logic [7:0] C_CLZ = 8'd104, C_CTZ = 8'd105, C_CPOP = 8'd106;
  localparam logic [7:0] C_SEXTB = 8'd107, C_SEXTH = 8'd108, C_ZEXTH = 8'd109;
  localparam logic [7:0] C_ROL = 8'd110, C_ROR = 8'd111, C_RORI = 8'd112;
  localparam logic [7:0] C_ORCB = 8'd113, C_REV8 = 8'd114, C_BSET = 8'd115;
  localparam logic [7:0] C_BCLR = 8'd116, C_BINV = 8'd117, C_BEXT = 8'd118;
  localparam logic [7:0] C_BSETI = 8'd119, C_BCLRI = 8'd120, C_BINVI = 8'd121;
  localparam logic [7:0] C_BEXTI = 8'd122;
  localparam logic [7:0] Q_ADDI4SPN = 8'd123, Q_LW = 8'd124, Q_FLW = 8'd125;
  localparam logic [7:0] Q_SW = 8'd126, Q_FSW = 8'd127, Q_NOP = 8'd128, Q_ADDI = 8'd129;
  localparam logic [7:0] Q_JAL = 8'd130, Q_LI = 8'd131, Q_ADDI16SP = 8'd132;
  localparam logic [7:0] Q_LUI = 8'd133, Q_SRLI = 8'd134, Q_SRAI = 8'd135;
  localparam logic [7:0] Q_ANDI = 8'd136, Q_SUB = 8'd137, Q_XOR = 8'd138, Q_OR = 8'd139;
  localparam logic [7:0] Q_AND = 8'd140, Q_J = 8'd141, Q_BEQZ = 8'd142, Q_BNEZ = 8'd143;
  localparam logic [7:0] Q_SLLI = 8'd144, Q_LWSP = 8'd145, Q_FLWSP = 8'd146;
  localparam logic [7:0] Q_JR = 8'd147, Q_MV = 8'd148, Q_EBREAK = 8'd149;
  localparam logic [7:0] Q_JALR = 8'd150, Q_ADD = 8'd151, Q_SWSP = 8'd152;
  localparam logic [7:0] Q_FSWSP = 8'd153, Q_LBU = 8'd154, Q_LHU = 8'd155, Q_LH = 8'd156;
  localparam logic [7:0] Q_SB = 8'd157, Q_SH = 8'd158, Q_ZEXTB = 8'd159;
  localparam logic [7:0] Q_SEXTB = 8'd160, Q_ZEXTH = 8'd161, Q_SEXTH = 8'd162;
  localparam logic [7:0] Q_NOT = 8'd163, Q_MUL = 8'd164, P_PUSH = 8'd165, P_POP = 8'd166;
  localparam logic [7:0] P_POPRET = 8'd167, P_POPRETZ = 8'd168, P_MVA01S = 8'd169;
  localparam logic [7:0] P_MVSA01 = 8'd170;

  localparam dec_t Miss = '{hit: 1'b0, cls: 8'd0};

  function automatic dec_t hit(input logic [7:0] c);
    hit = '{hit: 1'b1, cls: c};
  endfunction

  function automatic dec_t dec16(input logic [15:0] c);
    logic [1:0] q;
    logic [2:0] f3;
    logic [4:0] r7;
    logic [4:0] r2;
    q = c[1:0];
    f3 = c[15:13];
    r7 = c[11:7];
    r2 = c[6:2];
    dec16 = Miss;
    if (c == 16'h0 || q == 2'd3) begin
      dec16 = Miss;
    end else if ((c & 16'he003) == 16'ha002) begin
      case (c[12:8])
        5'h18: dec16 = hit(P_PUSH);
        5'h1a: dec16 = hit(P_POP);
        5'h1c: dec16 = hit(P_POPRETZ);
        5'h1e: dec16 = hit(P_POPRET);
        default: begin
          if (c[12:10] == 3'd3) dec16 = hit((c[6:5] == 2'd3) ? P_MVA01S : P_MVSA01);
        end
      endcase
    end else if (q == 2'd0) begin
      case (f3)
        3'd0: dec16 = hit(Q_ADDI4SPN);
        3'd2: dec16 = hit(Q_LW);
        3'd3: dec16 = hit(Q_FLW);
        3'd4: begin
          if (!c[12]) begin
            case (c[11:10])
              2'd0: dec16 = hit(Q_LBU);
              2'd1: dec16 = hit(c[6] ? Q_LH : Q_LHU);
              2'd2: dec16 = hit(Q_SB);
              default: dec16 = hit(Q_SH);
            endcase
          end
        end
        3'd6: dec16 = hit(Q_SW);
        3'd7: dec16 = hit(Q_FSW);
        default: dec16 = Miss;
      endcase
    end else if (q == 2'd1) begin
      case (f3)
        3'd0: dec16 = hit((r7 == 5'd0) ? Q_NOP : Q_ADDI);
        3'd1: dec16 = hit(Q_JAL);
        3'd2: dec16 = hit(Q_LI);
        3'd3: dec16 = hit((r7 == 5'd2) ? Q_ADDI16SP : Q_LUI);
        3'd4: begin
          case (c[12:10])
            3'd0, 3'd4: dec16 = hit(Q_SRLI);
            3'd1, 3'd5: dec16 = hit(Q_SRAI);
            3'd2, 3'd6: dec16 = hit(Q_ANDI);
            3'd3: begin
              case (c[6:5])
                2'd0: dec16 = hit(Q_SUB);
                2'd1: dec16 = hit(Q_XOR);
                2'd2: dec16 = hit(Q_OR);
                default: dec16 = hit(Q_AND);
              endcase
            end
            default: begin
              if (c[6:5] == 2'd2) begin
                dec16 = hit(Q_MUL);
              end else begin
                case (c[4:2])
                  3'd0: dec16 = hit(Q_ZEXTB);
                  3'd1: dec16 = hit(Q_SEXTB);
                  3'd2: dec16 = hit(Q_ZEXTH);
                  3'd3: dec16 = hit(Q_SEXTH);
                  3'd5: dec16 = hit(Q_NOT);
                  default: dec16 = Miss;
                endcase
              end
            end
          endcase
        end
        3'd5: dec16 = hit(Q_J);
        3'd6: dec16 = hit(Q_BEQZ);
        default: dec16 = hit(Q_BNEZ);
      endcase
    end else begin
      case (f3)
        3'd0: dec16 = hit(Q_SLLI);
        3'd2: dec16 = hit(Q_LWSP);
        3'd3: dec16 = hit(Q_FLWSP);
        3'd4: begin
          if (c[12]) begin
            if (r2 == 5'd0) dec16 = hit((r7 == 5'd0) ? Q_EBREAK : Q_JALR);
            else dec16 = hit(Q_ADD);
          end else begin
            dec16 = hit((r2 == 5'd0) ? Q_JR : Q_MV);
          end
        end
        3'd6: dec16 = hit(Q_SWSP);
        3'd7: dec16 = hit(Q_FSWSP);
        default: dec16 = Miss;
      endcase
    end
  endfunction

  function automatic dec_t bit_reg(input logic [6:0] f7, input logic [2:0] f3,
                                   input logic [4:0] rs2);
    bit_reg = Miss;
    case (f7)
      7'h04: if (f3 == 3'd4 && rs2 == 5'd0) bit_reg = hit(C_ZEXTH);
      7'h05: begin
        case (f3)
          3'd4: bit_reg = hit(C_MIN);
          3'd5: bit_reg = hit(C_MINU);
          3'd6: bit_reg = hit(C_MAX);
          3'd7: bit_reg = hit(C_MAXU);
          default: bit_reg = Miss;
        endcase
      end
      7'h10: begin
        case (f3)
          3'd2: bit_reg = hit(C_SH1ADD);
          3'd4: bit_reg = hit(C_SH2ADD);
          3'd6: bit_reg = hit(C_SH3ADD);
          default: bit_reg = Miss;
        endcase
      end
      7'h14: if (f3 == 3'd1) bit_reg = hit(C_BSET);
      7'h20: begin
        case (f3)
          3'd4: bit_reg = hit(C_XNOR);
          3'd6: bit_reg = hit(C_ORN);
          3'd7: bit_reg = hit(C_ANDN);
          default: bit_reg = Miss;
        endcase
      end
      7'h24: begin
        if (f3 == 3'd1) bit_reg = hit(C_BCLR);
        else if (f3 == 3'd5) bit_reg = hit(C_BEXT);
      end
      7'h30: begin
        if (f3 == 3'd1) bit_reg = hit(C_ROL);
        else if (f3 == 3'd5) bit_reg = hit(C_ROR);
      end
      7'h34: if (f3 == 3'd1) bit_reg = hit(C_BINV);
      default: bit_reg = Miss;
    endcase
  endfunction

  function automatic dec_t bit_imm(input logic [6:0] f7, input logic [2:0] f3,
                                   input logic [4:0] sh);
    bit_imm = Miss;
    case (f7)
      7'h14: begin
        if (f3 == 3'd1) bit_imm = hit(C_BSETI);
        else if (f3 == 3'd5 && sh == 5'd7) bit_imm = hit(C_ORCB);
      end
      7'h24: begin
        if (f3 == 3'd1) bit_imm = hit(C_BCLRI);
        else if (f3 == 3'd5) bit_imm = hit(C_BEXTI);
      end
      7'h30: begin
        if (f3 == 3'd5) begin
          bit_imm = hit(C_RORI);
        end else begin
          case (sh)
            5'd0: bit_imm = hit(C_CLZ);
            5'd1: bit_imm = hit(C_CTZ);
            5'd2: bit_imm = hit(C_CPOP);
            5'd4: bit_imm = hit(C_SEXTB);
            5'd5: bit_imm = hit(C_SEXTH);
            default: bit_imm = Miss;
          endcase
        end
      end
      7'h34: begin
        if (f3 == 3'd1) bit_imm = hit(C_BINVI);
        else if (f3 == 3'd5 && sh == 5'h18) bit_imm = hit(C_REV8);
      end
      default: bit_imm = Miss;
    endcase
  endfunction

  function automatic dec_t dec32(input logic [31:0] w);
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] rs2;
    op = w[6:0];
    f3 = w[14:12];
    f7 = w[31:25];
    rs2 = w[24:20];
    dec32 = Miss;
    case (op)
      7'h37: dec32 = hit(C_LUI);
      7'h17: dec32 = hit(C_AUIPC);
      7'h6f: dec32 = hit(C_JAL);
      7'h67: dec32 = hit(C_JALR);
      7'h63: begin
        case (f3)
          3'd0: dec32 = hit(C_BEQ);
          3'd1: dec32 = hit(C_BNE);
          3'd4: dec32 = hit(C_BLT);
          3'd5: dec32 = hit(C_BGE);
          3'd6: dec32 = hit(C_BLTU);
          3'd7: dec32 = hit(C_BGEU);
          default: dec32 = Miss;
        endcase
      end
      7'h03: begin
        case (f3)
          3'd0: dec32 = hit(C_LB);
          3'd1: dec32 = hit(C_LH);
          3'd2: dec32 = hit(C_LW);
          3'd4: dec32 = hit(C_LBU);
          3'd5: dec32 = hit(C_LHU);
          default: dec32 = Miss;
        endcase
      end
      7'h23: begin
        case (f3)
          3'd0: dec32 = hit(C_SB);
          3'd1: dec32 = hit(C_SH);
          3'd2: dec32 = hit(C_SW);
          default: dec32 = Miss;
        endcase
      end
      7'h07: if (f3 == 3'd2) dec32 = hit(C_FLW);
      7'h27: if (f3 == 3'd2) dec32 = hit(C_FSW);
      7'h13: begin
        case (f3)
          3'd0: dec32 = hit(C_ADDI);
          3'd1: dec32 = (f7 == 7'h0) ? hit(C_SLLI) : bit_imm(f7, f3, rs2);
          3'd2: dec32 = hit(C_SLTI);
          3'd3: dec32 = hit(C_SLTIU);
          3'd4: dec32 = hit(C_XORI);
          3'd5: begin
            if (f7 == 7'h0) dec32 = hit(C_SRLI);
            else if (f7 == 7'h20) dec32 = hit(C_SRAI);
            else dec32 = bit_imm(f7, f3, rs2);
          end
          3'd6: dec32 = hit(C_ORI);
          default: dec32 = hit(C_ANDI);
        endcase
      end
      7'h33: begin
        if (f7 == 7'h01) begin
          dec32 = hit(C_MUL + {5'd0, f3});
        end else if (f7 != 7'h0 && f7 != 7'h20) begin
          dec32 = bit_reg(f7, f3, rs2);
        end else begin
          case (f3)
            3'd0: dec32 = hit((f7 == 7'h20) ? C_SUB : C_ADD);
            3'd1: dec32 = hit(C_SLL);
            3'd2: dec32 = hit(C_SLT);
            3'd3: dec32 = hit(C_SLTU);
            3'd4: dec32 = (f7 == 7'h0) ? hit(C_XOR) : bit_reg(f7, f3, rs2);
            3'd5: dec32 = hit((f7 == 7'h20) ? C_SRA : C_SRL);
            3'd6: dec32 = (f7 == 7'h0) ? hit(C_OR) : bit_reg(f7, f3, rs2);
            default: dec32 = (f7 == 7'h0) ? hit(C_AND) : bit_reg(f7, f3, rs2);
          endcase
        end
      end
      7'h0f: dec32 = hit((f3 == 3'd1) ? C_FENCEI : C_FENCE);
      7'h73: begin
        case (f3)
          3'd0: begin
            if (w == 32'h00000073) dec32 = hit(C_ECALL);
            else if (w == 32'h00100073) dec32 = hit(C_EBRK);
            else if (w == 32'h30200073) dec32 = hit(C_MRET);
            else if (w == 32'h10500073) dec32 = hit(C_WFI);
          end
          3'd1: dec32 = hit(C_CSRRW);
          3'd2: dec32 = hit(C_CSRRS);
          3'd3: dec32 = hit(C_CSRRC);
          3'd5: dec32 = hit(C_CSRRWI);
          3'd6: dec32 = hit(C_CSRRSI);
          3'd7: dec32 = hit(C_CSRRCI);
          default: dec32 = Miss;
        endcase
      end
      7'h2f: begin
        case (w[31:27])
          5'h00: dec32 = hit(C_AMOADD);
          5'h01: dec32 = hit(C_AMOSWAP);
          5'h02: dec32 = hit(C_LRW);
          5'h03: dec32 = hit(C_SCW);
          5'h04: dec32 = hit(C_AMOXOR);
          5'h08: dec32 = hit(C_AMOOR);
          5'h0c: dec32 = hit(C_AMOAND);
          5'h10: dec32 = hit(C_AMOMIN);
          5'h14: dec32 = hit(C_AMOMAX);
          5'h18: dec32 = hit(C_AMOMINU);
          5'h1c: dec32 = hit(C_AMOMAXU);
          default: dec32 = Miss;
        endcase
      end
      7'h53: begin
        case (f7)
          7'h00: dec32 = hit(C_FADD);
          7'h04: dec32 = hit(C_FSUB);
          7'h08: dec32 = hit(C_FMUL);
          7'h0c: dec32 = hit(C_FDIV);
          7'h2c: dec32 = hit(C_FSQRT);
          7'h10: dec32 = hit((f3 == 3'd0) ? C_FSGNJ : ((f3 == 3'd1) ? C_FSGNJN : C_FSGNJX));
          7'h14: dec32 = hit((f3 == 3'd0) ? C_FMIN : C_FMAX);
          7'h50: dec32 = hit((f3 == 3'd0) ? C_FLE : ((f3 == 3'd1) ? C_FLT : C_FEQ));
          7'h60: dec32 = hit((rs2 == 5'd0) ? C_FCVTWS : C_FCVTWUS);
          7'h68: dec32 = hit((rs2 == 5'd0) ? C_FCVTSW : C_FCVTSWU);
          7'h70: dec32 = hit((f3 == 3'd0) ? C_FMVXW : C_FCLASS);
          7'h78: dec32 = hit(C_FMVWX);
          default: dec32 = Miss;
        endcase
      end
      7'h43: dec32 = hit(C_FMADD);
      7'h47: dec32 = hit(C_FMSUB);
      7'h4b: dec32 = hit(C_FNMSUB);
      7'h4f: dec32 = hit(C_FNMADD);
      default: dec32 = Miss;
    endcase
  endfunction

endpackage
`default_nettype wire

### design/ricc_decode.sv
// input register and instruction class decoder
`default_nettype none
module ricc_decode import ricc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire item_in_t item,
  output logic          vld,
  output logic [1:0]    kind,
  output logic [7:0]    read_index,
  output dec_t          dec
);

  item_in_t item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= take;
    end
    if (take) item_q <= item;
  end

  assign kind = item_q.kind;
  assign read_index = item_q.read_index;

  always_comb begin
    if (item_q.is_compressed) dec = dec16(item_q.insn[15:0]);
    else dec = dec32(item_q.insn);
  end

endmodule
`default_nettype wire

### design/ricc_counters.sv
// per-class counter bank with saturating update and result register
`default_nettype none
module ricc_counters import ricc_pkg::*; #(
  parameter int unsigned CounterWidth = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        vld,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  read_index,
  input  wire dec_t        dec,
  output logic             done,
  output item_out_t        result
);

  localparam logic [CounterWidth-1:0] CntMax = '1;

  // counter store with registered read; clear resets the per-class touched flags
  logic [CounterWidth-1:0] cnt [NumClasses];
  logic [NumClasses-1:0]   touched;
  logic [7:0]              seen;

  logic                    sel_ok;
  logic [7:0]              sel;

  // update stage, registered alongside the store read data
  logic                    upd_vld;
  logic [1:0]              upd_kind;
  logic                    upd_hit;
  logic [7:0]              upd_sel;
  logic                    upd_ok;
  logic [CounterWidth-1:0] rd_data;
  logic                    fwd;
  logic [CounterWidth-1:0] fwd_data;
  logic [CounterWidth-1:0] raw;

  logic [CounterWidth-1:0] cur;
  logic [CounterWidth-1:0] bumped;
  logic [31:0]             cur32;
  logic [31:0]             bumped32;
  logic [7:0]              seen_next;
  item_out_t               result_next;
  logic                    note_hit;

  assign sel = (kind == KIND_NOTE) ? dec.cls : read_index;
  assign sel_ok = sel < 8'(NumClasses);

  assign note_hit = upd_vld && upd_kind == KIND_NOTE && upd_hit;
  // a counter written at the edge of the read is taken from the write data
  assign raw = fwd ? fwd_data : rd_data;
  assign cur = (upd_ok && touched[upd_sel]) ? raw : '0;
  assign bumped = (cur == CntMax) ? cur : cur + 1'b1;

  if (CounterWidth >= 32) begin : g_wide
    assign cur32 = cur[31:0];
    assign bumped32 = bumped[31:0];
  end else begin : g_narrow
    assign cur32 = {{(32-CounterWidth){1'b0}}, cur};
    assign bumped32 = {{(32-CounterWidth){1'b0}}, bumped};
  end

  always_comb begin
    seen_next = seen;
    result_next = '0;
    case (upd_kind)
      KIND_NOTE: begin
        if (upd_hit) begin
          if (!touched[upd_sel]) seen_next = seen + 8'd1;
          result_next.class_index = upd_sel;
          result_next.recognized = 1'b1;
          result_next.count_value = bumped32;
        end
      end
      KIND_READ: begin
        result_next.class_index = upd_sel;
        result_next.recognized = upd_ok;
        result_next.count_value = upd_ok ? cur32 : 32'd0;
      end
      KIND_CLEAR: seen_next = 8'd0;
      default: seen_next = seen;
    endcase
    result_next.distinct_seen = seen_next;
  end

  always_ff @(posedge clk) begin
    if (note_hit) cnt[upd_sel] <= bumped;
    if (vld && sel_ok) rd_data <= cnt[sel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
      seen <= 8'd0;
      upd_vld <= 1'b0;
      fwd <= 1'b0;
      done <= 1'b0;
    end else begin
      upd_vld <= vld;
      fwd <= note_hit && upd_sel == sel;
      done <= upd_vld;
      if (upd_vld) begin
        seen <= seen_next;
        if (upd_kind == KIND_CLEAR) touched <= '0;
        else if (note_hit) touched[upd_sel] <= 1'b1;
      end
    end
    if (vld) begin
      upd_kind <= kind;
      upd_hit <= dec.hit;
      upd_sel <= sel;
      upd_ok <= sel_ok;
    end
    fwd_data <= bumped;
    if (upd_vld) result <= result_next;
  end

endmodule
`default_nettype wire

### design/riscv_instruction_coverage_counter_top.sv
// top level of the retired-instruction coverage counter
`default_nettype none
// From start to strobe, an item is first registered and its instruction decoded, then its
// class counter is read from its store, then the counter is updated and the result
// registered. busy is never raised, so a new item may start in every cycle;
// the receiver cannot stall and must take each result in the single cycle that strobe
// is high. Clear zeroes all counters through per-class touched flags.
module riscv_instruction_coverage_counter_top import ricc_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire item_in_t item,
  output logic          busy,
  output logic          strobe,
  output item_out_t     result
);

  logic       vld;
  logic [1:0] kind;
  logic [7:0] read_index;
  dec_t       dec;

  assign busy = 1'b0;

  ricc_decode u_decode (
    .clk, .rst, .take(start && !busy), .item,
    .vld, .kind, .read_index, .dec
  );

  ricc_counters #(.CounterWidth(COUNTER_WIDTH)) u_counters (
    .clk, .rst, .vld, .kind, .read_index, .dec,
    .done(strobe), .result
  );

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    vld |-> ##2 strobe) else $error("missing result strobe");
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (vld && kind == KIND_CLEAR) |-> ##2 (result.distinct_seen == 8'd0 && !result.recognized))
    else $error("clear result wrong");
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    strobe |-> result.distinct_seen <= 8'(NumClasses)) else $error("seen overflow");
  a_unrec_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.recognized) |-> result.count_value == 32'd0)
    else $error("count on miss");

endmodule
`default_nettype wire
